@@ sv/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	localparam int FIELD_W   = 7;   // width of the pin, edge and result masks
	localparam int SETTLE_W  = 8;
	localparam int HELD_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_POLL  = 2'd1,
		CMD_EDGE  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_WAITING  = 2'd1,
		PH_PRESSED  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_SHORT = 2'd1,
		ACT_LONG  = 2'd2
	} action_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd2;

	localparam logic [FIELD_W-1:0]  PRESSED_LEVEL_RST = 7'd31;
	localparam logic [SETTLE_W-1:0] DEBOUNCE_RST      = 8'd4;
	localparam logic [HELD_W-1:0]   LONG_PRESS_RST    = 16'd1000;

	// Timing configuration shared by every button
	typedef struct packed {
		logic [SETTLE_W-1:0] debounce_ticks;
		logic [HELD_W-1:0]   long_press_ticks;
	} timing_cfg_t;

	// One request as seen by a single button
	typedef struct packed {
		logic en;        // request is being executed this cycle
		cmd_t command;
		logic down;      // pin level means pressed
		logic edge_hit;  // edge interrupt fired for this button
	} btn_req_t;

	// Status of a single button after the request has taken effect
	typedef struct packed {
		logic short_act;
		logic long_act;
		logic pressed;
	} btn_stat_t;

endpackage

@@ sv/bdpc_req_if.sv @@
// ----------------------------------------------------------------------------
// bdpc_req_if
// Request channel: command, raw pin levels and edge mask.
// ----------------------------------------------------------------------------
interface bdpc_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [bdpc_pkg::FIELD_W-1:0]  pin_levels;
	logic [bdpc_pkg::FIELD_W-1:0]  edge_mask;

	modport source (output valid, command, pin_levels, edge_mask, input ready);
	modport sink   (input valid, command, pin_levels, edge_mask, output ready);
endinterface

@@ sv/bdpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bdpc_rsp_if
// Result channel: short, long and debounced masks.
// ----------------------------------------------------------------------------
interface bdpc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bdpc_pkg::FIELD_W-1:0]  short_mask;
	logic [bdpc_pkg::FIELD_W-1:0]  long_mask;
	logic [bdpc_pkg::FIELD_W-1:0]  debounced_mask;

	modport source (output valid, short_mask, long_mask, debounced_mask, input ready);
	modport sink   (input valid, short_mask, long_mask, debounced_mask, output ready);
endinterface

@@ sv/bdpc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bdpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bdpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bdpc_pkg::CFG_IDX_W-1:0]  index;
	logic [bdpc_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bdpc_button.sv @@
// ----------------------------------------------------------------------------
// bdpc_button
// Per-button debounce machine and short/long press classifier.
// ----------------------------------------------------------------------------
module bdpc_button (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bdpc_pkg::timing_cfg_t  cfg,
	input  bdpc_pkg::btn_req_t     req,
	output bdpc_pkg::btn_stat_t    stat
);

	bdpc_pkg::phase_t                 phase_q, phase_d;
	logic [bdpc_pkg::SETTLE_W-1:0]    settle_q, settle_d;
	logic [bdpc_pkg::HELD_W-1:0]      held_q, held_d;
	logic                             await_q, await_d;
	bdpc_pkg::action_t                act_q, act_d;
	logic                             armed_q, armed_d;

	always_comb begin
		phase_d  = phase_q;
		settle_d = settle_q;
		held_d   = held_q;
		await_d  = await_q;
		act_d    = act_q;
		armed_d  = armed_q;
		if (req.en) begin
			case (req.command)
				bdpc_pkg::CMD_TICK: begin
					if (settle_q < cfg.debounce_ticks) begin
						settle_d = settle_q + 8'd1;
					end
					if (phase_q == bdpc_pkg::PH_PRESSED) begin
						if (held_q != '1) begin
							held_d = held_q + 16'd1;
						end
					end else begin
						held_d = '0;
					end
				end
				bdpc_pkg::CMD_POLL: begin
					if (armed_q) begin
						case (phase_q)
							bdpc_pkg::PH_WAITING: begin
								if (settle_q >= cfg.debounce_ticks) begin
									if (req.down) begin
										phase_d = bdpc_pkg::PH_PRESSED;
									end else begin
										phase_d = bdpc_pkg::PH_RELEASED;
										armed_d = 1'b0;
									end
								end
							end
							bdpc_pkg::PH_PRESSED: begin
								if (!req.down) begin
									phase_d  = bdpc_pkg::PH_WAITING;
									settle_d = '0;
								end
							end
							default: begin
								// released, and any stray code treated as released
								phase_d = bdpc_pkg::PH_RELEASED;
								if (req.down) begin
									phase_d  = bdpc_pkg::PH_WAITING;
									settle_d = '0;
								end
							end
						endcase
					end
					// classify on the updated phase
					if (act_q == bdpc_pkg::ACT_NONE) begin
						if (!await_q) begin
							if (phase_d == bdpc_pkg::PH_PRESSED) begin
								await_d = 1'b1;
							end
						end else if (held_q >= cfg.long_press_ticks) begin
							act_d   = bdpc_pkg::ACT_LONG;
							await_d = 1'b0;
						end else if (phase_d == bdpc_pkg::PH_RELEASED) begin
							act_d   = bdpc_pkg::ACT_SHORT;
							await_d = 1'b0;
						end
					end
				end
				bdpc_pkg::CMD_EDGE: begin
					if (req.edge_hit) begin
						armed_d = 1'b1;
					end
				end
				bdpc_pkg::CMD_CLEAR: begin
					act_d = bdpc_pkg::ACT_NONE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bdpc_pkg::PH_RELEASED;
			settle_q <= '0;
			held_q   <= '0;
			await_q  <= 1'b0;
			act_q    <= bdpc_pkg::ACT_NONE;
			armed_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			settle_q <= settle_d;
			held_q   <= held_d;
			await_q  <= await_d;
			act_q    <= act_d;
			armed_q  <= armed_d;
		end
	end

	// status reflects the state after this request
	assign stat.short_act = (act_d == bdpc_pkg::ACT_SHORT);
	assign stat.long_act  = (act_d == bdpc_pkg::ACT_LONG);
	assign stat.pressed   = (phase_d == bdpc_pkg::PH_PRESSED);

endmodule

@@ sv/button_debounce_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a set of buttons and latches short or long press actions.
// ----------------------------------------------------------------------------
//
//  channel  role   payload                                      request moves
//  req      sink   command, pin_levels, edge_mask               one command
//  rsp      source short_mask, long_mask, debounced_mask        one status
//  cfg      sink   index, data                                  one reg write
//
//  Cycles: one request per cycle sustained while rsp is ready; a status
//  passes the request register, then the status register. The per-button
//  machines update in the cycle between those two registers.
//  Reset: config returns to its defaults and every button goes to released,
//  disarmed, with no latched action; no clearing pass is needed.
//  Stalls: while rsp is held off, one status and one request stay parked and
//  req drops ready; cfg is always ready.
//
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	bdpc_req_if.sink      req,
	bdpc_rsp_if.source    rsp,
	bdpc_cfg_if.sink      cfg
);

	localparam int FW = bdpc_pkg::FIELD_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [FW-1:0]                  level_mask_q;
	bdpc_pkg::timing_cfg_t          timing_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mask_q              <= bdpc_pkg::PRESSED_LEVEL_RST;
			timing_q.debounce_ticks   <= bdpc_pkg::DEBOUNCE_RST;
			timing_q.long_press_ticks <= bdpc_pkg::LONG_PRESS_RST;
		end else if (cfg.valid) begin
			// drop writes to indexes beyond the register list
			unique case (cfg.index)
				bdpc_pkg::CFG_PRESSED_LEVEL: level_mask_q <= cfg.data[FW-1:0];
				bdpc_pkg::CFG_DEBOUNCE: begin
					timing_q.debounce_ticks <= cfg.data[bdpc_pkg::SETTLE_W-1:0];
				end
				bdpc_pkg::CFG_LONG_PRESS: begin
					timing_q.long_press_ticks <= cfg.data[bdpc_pkg::HELD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Request register (stage 1)
	// ------------------------------------------------------------------
	logic                  valid_s1;
	bdpc_pkg::cmd_t        command_s1;
	logic [FW-1:0]         pins_s1;
	logic [FW-1:0]         edges_s1;
	logic                  rsp_valid_q;
	logic                  advance;

	// execute the parked request whenever the status register can take it
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			command_s1 <= bdpc_pkg::cmd_t'(req.command);
			pins_s1    <= req.pin_levels;
			edges_s1   <= req.edge_mask;
		end
	end

	// ------------------------------------------------------------------
	// Per-button machines
	// ------------------------------------------------------------------
	bdpc_pkg::btn_stat_t stat [NUM_BUTTONS];

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		bdpc_pkg::btn_req_t btn_req;
		logic               level;
		logic               polarity;
		logic               edge_bit;

		// buttons beyond the mask width see level 0, polarity 0 and no edge
		if (i < FW) begin : g_wired
			assign level    = pins_s1[i];
			assign polarity = level_mask_q[i];
			assign edge_bit = edges_s1[i];
		end else begin : g_unwired
			assign level    = 1'b0;
			assign polarity = 1'b0;
			assign edge_bit = 1'b0;
		end

		assign btn_req.en       = advance;
		assign btn_req.command  = command_s1;
		assign btn_req.down     = (level == polarity);
		assign btn_req.edge_hit = edge_bit;

		bdpc_button u_button (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (timing_q),
			.req    (btn_req),
			.stat   (stat[i])
		);
	end

	// ------------------------------------------------------------------
	// Status register
	// ------------------------------------------------------------------
	logic [FW-1:0] short_d, long_d, down_d;
	logic [FW-1:0] short_q, long_q, down_q;

	for (genvar j = 0; j < FW; j++) begin : g_mask
		if (j < NUM_BUTTONS) begin : g_used
			assign short_d[j] = stat[j].short_act;
			assign long_d[j]  = stat[j].long_act;
			assign down_d[j]  = stat[j].pressed;
		end else begin : g_absent
			assign short_d[j] = 1'b0;
			assign long_d[j]  = 1'b0;
			assign down_d[j]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			short_q <= short_d;
			long_q  <= long_d;
			down_q  <= down_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.short_mask     = short_q;
	assign rsp.long_mask      = long_q;
	assign rsp.debounced_mask = down_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_excl_actions: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((short_q & long_q) == '0))
		else $error("button latched both short and long action");

	a_exec_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("executed request produced no status");

	a_clear_drops_all: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && command_s1 == bdpc_pkg::CMD_CLEAR) |=>
			(short_q == '0 && long_q == '0))
		else $error("clear left a latched action");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("empty request register refused a request");

	a_stall_parks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> $stable(short_q) && $stable(long_q)
			&& $stable(down_q))
		else $error("status changed while stalled");

endmodule

@@ verif/bdpc_press_checker.sv @@
// ----------------------------------------------------------------------------
// bdpc_press_checker
// Watches the command, status and register channels of the press classifier.
// Each accepted command is applied to a private copy of the button machines,
// and each accepted status is compared field by field with the oldest status
// still expected.
// ----------------------------------------------------------------------------
module bdpc_press_checker #(
	parameter int NUM_BUTTONS = 7
) (
	input  logic clk,
	input  logic arst_n,
	bdpc_req_if  req,
	bdpc_rsp_if  rsp,
	bdpc_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bdpc_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] short_m;
		logic [FIELD_W-1:0] long_m;
		logic [FIELD_W-1:0] debounced;
	} press_status_t;

	// Register copies
	logic [FIELD_W-1:0]  level_polarity;
	logic [SETTLE_W-1:0] settle_limit;
	logic [HELD_W-1:0]   long_limit;

	// Per-button machine copies
	phase_t              btn_phase  [NUM_BUTTONS];
	logic [SETTLE_W-1:0] settle_cnt [NUM_BUTTONS];
	logic [HELD_W-1:0]   held_cnt   [NUM_BUTTONS];
	logic                timing     [NUM_BUTTONS];
	action_t             latched    [NUM_BUTTONS];
	logic                watching   [NUM_BUTTONS];

	press_status_t status_q [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic void reset_buttons();
		level_polarity = PRESSED_LEVEL_RST;
		settle_limit   = DEBOUNCE_RST;
		long_limit     = LONG_PRESS_RST;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_phase[i]  = PH_RELEASED;
			settle_cnt[i] = '0;
			held_cnt[i]   = '0;
			timing[i]     = 1'b0;
			latched[i]    = ACT_NONE;
			watching[i]   = 1'b0;
		end
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] value);
		case (idx)
			CFG_PRESSED_LEVEL: level_polarity = value[FIELD_W-1:0];
			CFG_DEBOUNCE:      settle_limit   = value[SETTLE_W-1:0];
			CFG_LONG_PRESS:    long_limit     = value[HELD_W-1:0];
			default: ;
		endcase
	endfunction

	// Apply one command to the button copies and return the status it leaves
	function automatic press_status_t apply_command(input cmd_t op,
			input logic [FIELD_W-1:0] levels, input logic [FIELD_W-1:0] edges);
		press_status_t st;
		logic          down;
		st = '0;
		case (op)
			CMD_TICK: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (settle_cnt[i] < settle_limit)
						settle_cnt[i] = settle_cnt[i] + 1'b1;
					if (btn_phase[i] == PH_PRESSED) begin
						if (held_cnt[i] != '1)
							held_cnt[i] = held_cnt[i] + 1'b1;
					end else begin
						held_cnt[i] = '0;
					end
				end
			end
			CMD_POLL: begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (watching[i]) begin
						// unwired buttons see level 0 against polarity 0
						down = (i < FIELD_W) ? (levels[i] == level_polarity[i]) : 1'b1;
						case (btn_phase[i])
							PH_WAITING: begin
								if (settle_cnt[i] >= settle_limit) begin
									if (down) begin
										btn_phase[i] = PH_PRESSED;
									end else begin
										btn_phase[i] = PH_RELEASED;
										watching[i]  = 1'b0;
									end
								end
							end
							PH_PRESSED: begin
								if (!down) begin
									btn_phase[i]  = PH_WAITING;
									settle_cnt[i] = '0;
								end
							end
							default: begin
								btn_phase[i] = PH_RELEASED;
								if (down) begin
									btn_phase[i]  = PH_WAITING;
									settle_cnt[i] = '0;
								end
							end
						endcase
					end
				end
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (latched[i] == ACT_NONE) begin
						if (!timing[i]) begin
							if (btn_phase[i] == PH_PRESSED)
								timing[i] = 1'b1;
						end else if (held_cnt[i] >= long_limit) begin
							latched[i] = ACT_LONG;
							timing[i]  = 1'b0;
						end else if (btn_phase[i] == PH_RELEASED) begin
							latched[i] = ACT_SHORT;
							timing[i]  = 1'b0;
						end
					end
				end
			end
			CMD_EDGE: begin
				for (int i = 0; i < NUM_BUTTONS && i < FIELD_W; i++)
					if (edges[i])
						watching[i] = 1'b1;
			end
			default: begin
				for (int i = 0; i < NUM_BUTTONS; i++)
					latched[i] = ACT_NONE;
			end
		endcase
		for (int i = 0; i < NUM_BUTTONS && i < FIELD_W; i++) begin
			st.short_m[i]   = (latched[i] == ACT_SHORT);
			st.long_m[i]    = (latched[i] == ACT_LONG);
			st.debounced[i] = (btn_phase[i] == PH_PRESSED);
		end
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		press_status_t want;
		int            pushed;
		int            popped;
		if (!arst_n) begin
			reset_buttons();
			status_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			if (cfg.valid && cfg.ready)
				write_register(cfg.index, cfg.data);
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("status with no command waiting",
						32'({rsp.short_mask, rsp.long_mask, rsp.debounced_mask}), '0);
				end else begin
					want   = status_q.pop_front();
					popped = 1;
					if (rsp.short_mask !== want.short_m)
						report_mismatch("short_mask", 32'(rsp.short_mask),
							32'(want.short_m));
					if (rsp.long_mask !== want.long_m)
						report_mismatch("long_mask", 32'(rsp.long_mask),
							32'(want.long_m));
					if (rsp.debounced_mask !== want.debounced)
						report_mismatch("debounced_mask", 32'(rsp.debounced_mask),
							32'(want.debounced));
				end
			end
			if (req.valid && req.ready) begin
				status_q.push_back(apply_command(cmd_t'(req.command), req.pin_levels,
					req.edge_mask));
				pushed = 1;
			end
			outstanding <= outstanding + pushed - popped;
		end
	end

endmodule

@@ verif/tb_button_debounce_press_classifier.sv @@
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier
// Drives the press classifier with a short directed sequence, then with random
// press and release traffic under several register settings, and ends with a
// long-hold run past the long-press limit. Both channel sides idle at random;
// the checker beside the block predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import bdpc_pkg::*;

	localparam int CYCLE_LIMIT     = 100_000;
	localparam int RSP_HOLD_CYCLES = 300;      // long hold-off on the status side
	localparam int DRAIN_CYCLES    = 8;        // settle time after the final drain
	localparam int LONG_HOLD_TICKS = 48;       // past the long limit of the last run

	// Register index that maps to nothing and must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	bdpc_req_if req ();
	bdpc_rsp_if rsp ();
	bdpc_cfg_if cfg ();

	int          mismatches;
	int          outstanding;
	int unsigned cycle_count;

	// Sender and stimulus state
	int                 burst_left;
	bit                 hold_rsp;       // ask the status side for a long hold-off
	logic [FIELD_W-1:0] polarity;       // pressed level currently programmed
	logic [FIELD_W-1:0] held_keys;      // buttons the "user" is holding down
	logic [FIELD_W-1:0] edge_flags;     // buttons that changed since the last edge

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	button_debounce_press_classifier #(
		.NUM_BUTTONS(7)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	bdpc_press_checker #(
		.NUM_BUTTONS(7)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Hand one request to the block. The sender works in bursts: when a burst
	// runs out, maybe drop valid for a random gap and pick a new burst length.
	task automatic send_request(input cmd_t op, input logic [FIELD_W-1:0] levels,
			input logic [FIELD_W-1:0] edges);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req.valid      <= 1'b1;
		req.command    <= op;
		req.pin_levels <= levels;
		req.edge_mask  <= edges;
		// hold the request until the block takes it
		do @(posedge clk); while (!req.ready);
		burst_left--;
	endtask

	// Stop offering requests and wait until every expected status has come back
	task automatic drain_status();
		req.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Program all three registers back to back; junk in the unused upper data
	// bits must be dropped by the block. Optionally poke the unmapped index.
	task automatic apply_settings(input logic [FIELD_W-1:0] level_mask,
			input logic [SETTLE_W-1:0] settle, input logic [HELD_W-1:0] long_hold,
			input bit poke_unused);
		logic [CFG_IDX_W-1:0] idx  [4];
		logic [CFG_DAT_W-1:0] word [4];
		int                   n;
		idx[0]  = CFG_PRESSED_LEVEL;
		word[0] = {9'($urandom), level_mask};
		idx[1]  = CFG_DEBOUNCE;
		word[1] = {8'($urandom), settle};
		idx[2]  = CFG_LONG_PRESS;
		word[2] = long_hold;
		idx[3]  = CFG_UNUSED;
		word[3] = 16'($urandom);
		n = poke_unused ? 4 : 3;
		for (int k = 0; k < n; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[k];
			cfg.data  <= word[k];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		polarity = level_mask;
	endtask

	// One random request shaped like real use: buttons go down and up now and
	// then, polls mostly report those levels with the programmed polarity, and
	// edge events arm the buttons that changed. A slice of polls carries bounce
	// noise, and some edge events get random extra bits in their masks.
	task automatic send_random_item();
		int                 roll;
		logic [FIELD_W-1:0] flips;
		logic [FIELD_W-1:0] levels;
		flips = '0;
		for (int b = 0; b < FIELD_W; b++)
			if ($urandom_range(0, 39) == 0)
				flips[b] = 1'b1;
		held_keys  ^= flips;
		edge_flags |= flips;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			send_request(CMD_TICK, 7'($urandom), 7'($urandom));
		end else if (roll < 80) begin
			levels = ~(held_keys ^ polarity);
			if ($urandom_range(0, 5) == 0)
				levels ^= 7'($urandom);
			send_request(CMD_POLL, levels, 7'($urandom));
		end else if (roll < 93) begin
			send_request(CMD_EDGE, 7'($urandom),
				edge_flags | (($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'd0));
			edge_flags = '0;
		end else begin
			send_request(CMD_CLEAR, 7'($urandom), 7'($urandom));
		end
	endtask

	task automatic run_traffic(input int count);
		for (int k = 0; k < count; k++)
			send_random_item();
	endtask

	// Status side: stall on a pattern of its own, switching between always
	// ready, coin-flip ready and an even on-off beat. On request, hold
	// off for a long stretch counted right here.
	initial begin : status_sink
		int          seg_left;
		int          rsp_mode;
		int unsigned beat;
		seg_left = 0;
		rsp_mode = 0;
		beat     = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp.ready <= 1'b0;
				for (int k = 0; k < RSP_HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				if (seg_left == 0) begin
					rsp_mode = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				beat++;
				case (rsp_mode)
					0:       rsp.ready <= 1'b1;
					1:       rsp.ready <= 1'($urandom_range(0, 1));
					default: rsp.ready <= ((beat % 6) < 3);
				endcase
			end
		end
	end

	// Watchdog that fails the run once the cycle limit is reached
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.command    <= CMD_TICK;
		req.pin_levels <= '0;
		req.edge_mask  <= '0;
		cfg.valid      <= 1'b0;
		cfg.index      <= CFG_PRESSED_LEVEL;
		cfg.data       <= '0;
		burst_left = 0;
		hold_rsp   = 1'b0;
		polarity   = PRESSED_LEVEL_RST;
		held_keys  = '0;
		edge_flags = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: buttons 0-4 are pressed on a high
		// level, 5-6 on a low one, so 0x1F reads as all down and 0x60 all up.
		send_request(CMD_CLEAR, 7'h00, 7'h00);
		send_request(CMD_POLL, 7'h1F, 7'h00);     // nothing armed yet: ignored
		send_request(CMD_POLL, 7'h7F, 7'h7F);     // edge field unused by poll
		send_request(CMD_EDGE, 7'h00, 7'h7F);     // arm every button
		send_request(CMD_POLL, 7'h1F, 7'h00);     // all go to waiting
		send_request(CMD_POLL, 7'h1F, 7'h00);     // debounce not yet elapsed
		repeat (4) send_request(CMD_TICK, 7'h00, 7'h00);
		send_request(CMD_POLL, 7'h1F, 7'h00);     // all pressed, press timed
		send_request(CMD_TICK, 7'h7F, 7'h7F);
		send_request(CMD_POLL, 7'h60, 7'h00);     // let go: back to waiting
		repeat (4) send_request(CMD_TICK, 7'h00, 7'h00);
		send_request(CMD_POLL, 7'h60, 7'h00);     // released, short press latches
		send_request(CMD_EDGE, 7'h7F, 7'h00);     // empty edge arms nothing
		send_request(CMD_CLEAR, 7'h7F, 7'h7F);
		send_request(CMD_POLL, 7'h00, 7'h7F);     // disarmed after release
		drain_status();

		// Zero debounce, long press after a single tick, all pressed-low
		apply_settings(7'h00, 8'd0, 16'd1, 1'b0);
		run_traffic(130);
		drain_status();

		// Largest settings; waits started here carry over into the next phase
		apply_settings(7'h7F, 8'd255, 16'hFFFF, 1'b0);
		run_traffic(60);
		drain_status();

		// Lower the debounce below counts already reached, and a zero long
		// press; poke the unmapped register index too
		apply_settings(7'h2A, 8'd3, 16'd0, 1'b1);
		run_traffic(130);
		drain_status();

		// Hold off the status side for a long stretch while requests keep
		// coming, so the block backs up and stalls its request side
		apply_settings(7'h55, 8'd2, 16'd12, 1'b0);
		hold_rsp = 1'b1;
		run_traffic(130);
		drain_status();

		// Random settings, with a full pause halfway through
		apply_settings(7'($urandom), 8'($urandom_range(0, 6)), 16'($urandom_range(1, 40)),
			1'b0);
		run_traffic(65);
		drain_status();
		run_traffic(65);
		drain_status();

		// Back to the reset values
		apply_settings(PRESSED_LEVEL_RST, DEBOUNCE_RST, LONG_PRESS_RST, 1'b0);
		run_traffic(50);
		drain_status();

		// Long hold: press button 0 and tick past the long-press limit
		apply_settings(7'h7F, 8'd0, 16'd40, 1'b0);
		send_request(CMD_CLEAR, 7'h00, 7'h00);
		send_request(CMD_EDGE, 7'h00, 7'h01);
		send_request(CMD_POLL, 7'h7F, 7'h00);
		send_request(CMD_POLL, 7'h7F, 7'h00);
		repeat (LONG_HOLD_TICKS) send_request(CMD_TICK, 7'h00, 7'h00);
		send_request(CMD_POLL, 7'h7F, 7'h00);

		drain_status();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/bdpc_pkg.sv
sv/bdpc_req_if.sv
sv/bdpc_rsp_if.sv
sv/bdpc_cfg_if.sv
sv/bdpc_button.sv
sv/button_debounce_press_classifier.sv
verif/bdpc_press_checker.sv
verif/tb_button_debounce_press_classifier.sv
